### sv/tvqg_pkg.sv
// ============================================================================
// Torus vertex generator package
// Shared widths, register indexes, CORDIC constants and the quadrant struct
// carried through the pipeline of the torus vertex and quad generator.
// ============================================================================
package tvqg_pkg;

    localparam int MaxRingSize = 256;
    localparam int PhaseBits   = 16;
    localparam int CordicSteps = 16;
    localparam int CntW        = 9;

    localparam logic [2:0] REG_MAJOR   = 3'd0;
    localparam logic [2:0] REG_MINOR   = 3'd1;
    localparam logic [2:0] REG_RINGS   = 3'd2;
    localparam logic [2:0] REG_POINTS  = 3'd3;
    localparam logic [2:0] REG_RSTEP   = 3'd4;
    localparam logic [2:0] REG_PSTEP   = 3'd5;

    localparam logic signed [33:0] CordicStart = 34'sd652032874;

    typedef logic signed [33:0] t_cval;

    function automatic t_cval atan_turn(input int i);
        t_cval v;
        unique case (i)
            0:  v = 34'sh20000000;
            1:  v = 34'sh12E4051E;
            2:  v = 34'sh09FB385B;
            3:  v = 34'sh051111D4;
            4:  v = 34'sh028B0D43;
            5:  v = 34'sh0145D7E1;
            6:  v = 34'sh00A2F61E;
            7:  v = 34'sh00517C55;
            8:  v = 34'sh0028BE53;
            9:  v = 34'sh00145F2F;
            10: v = 34'sh000A2F98;
            11: v = 34'sh000517CC;
            12: v = 34'sh00028BE6;
            13: v = 34'sh000145F3;
            14: v = 34'sh0000A2FA;
            default: v = 34'sh0000517D;
        endcase
        return v;
    endfunction

    typedef struct packed {
        logic [1:0] quad_o;
        logic [1:0] quad_g;
    } t_quads;

endpackage

### sv/torus_vertex_and_quad_generator.sv
// ============================================================================
// Torus vertex and quad generator
// Computes a torus vertex from two grid indexes with pipelined CORDIC and
// multipliers, and the four corner indexes of the quad that starts there.
// ============================================================================
// Throughput: one word per cycle while not stalled, set by the fully pipelined CORDIC stages.
// A stall freezes the whole pipeline; the output register holds its word.
// Reset clears the valid bits and loads the register reset values.
module torus_vertex_and_quad_generator (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [7:0]           i_ring_index,
    input  logic [7:0]           i_point_index,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [17:0]   o_x_coord,
    output logic signed [17:0]   o_y_coord,
    output logic signed [17:0]   o_z_coord,
    output logic [15:0]          o_corner_here,
    output logic [15:0]          o_corner_next_ring,
    output logic [15:0]          o_corner_next_both,
    output logic [15:0]          o_corner_next_point,
    output logic                 o_index_error,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    localparam int CW   = tvqg_pkg::CntW;
    localparam int NCOR = tvqg_pkg::CordicSteps + 1;
    localparam int LAT  = NCOR + 6;

    logic [15:0]   r_major, r_minor, r_rstep, r_pstep;
    logic [CW-1:0] r_rings, r_points;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_major  <= 16'd512;
            r_minor  <= 16'd256;
            r_rings  <= 9'd100;
            r_points <= 9'd100;
            r_rstep  <= 16'd655;
            r_pstep  <= 16'd655;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tvqg_pkg::REG_MAJOR:  r_major  <= i_cfg_data;
                tvqg_pkg::REG_MINOR:  r_minor  <= i_cfg_data;
                tvqg_pkg::REG_RINGS:  r_rings  <= i_cfg_data[CW-1:0];
                tvqg_pkg::REG_POINTS: r_points <= i_cfg_data[CW-1:0];
                tvqg_pkg::REG_RSTEP:  r_rstep  <= i_cfg_data;
                tvqg_pkg::REG_PSTEP:  r_pstep  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic          adv;
    logic [LAT-1:0] r_vld;
    assign adv     = !(o_valid && i_stall);
    assign o_stall = !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (adv) r_vld <= {r_vld[LAT-2:0], i_valid};
    end

    // Stage A: clamp counts, phases, error check.
    logic [CW-1:0] n_n, n_m;
    assign n_n = (r_rings  > CW'(tvqg_pkg::MaxRingSize)) ? CW'(tvqg_pkg::MaxRingSize) : r_rings;
    assign n_m = (r_points > CW'(tvqg_pkg::MaxRingSize)) ? CW'(tvqg_pkg::MaxRingSize) : r_points;

    logic [15:0]   r_pho, r_phg;
    logic [7:0]    r_ri, r_pi;
    logic [CW-1:0] r_m, r_n;
    logic          r_err;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pho <= 16'(i_ring_index) * r_rstep;
            r_phg <= 16'(i_point_index) * r_pstep;
            r_ri  <= i_ring_index;
            r_pi  <= i_point_index;
            r_m   <= n_m;
            r_n   <= n_n;
            r_err <= ({1'b0, i_ring_index} >= n_n) || ({1'b0, i_point_index} >= n_m);
        end
    end

    logic [31:0] pho32, phg32, pmask;
    assign pmask = ~(32'hFFFF_FFFF >> tvqg_pkg::PhaseBits);
    assign pho32 = {r_pho, 16'd0} & pmask;
    assign phg32 = {r_phg, 16'd0} & pmask;

    tvqg_pkg::t_cval  c_xo, c_yo, c_xg, c_yg;
    tvqg_pkg::t_quads c_q;

    tvqg_cordic u_cordic (
        .i_clk     (i_clk),
        .i_en      (adv),
        .i_phase_o (pho32),
        .i_phase_g (phg32),
        .o_xo      (c_xo),
        .o_yo      (c_yo),
        .o_xg      (c_xg),
        .o_yg      (c_yg),
        .o_quads   (c_q)
    );

    // Side pipe: corner indexes computed early and delayed.
    logic [15:0] r_sd_ch [NCOR+4];
    logic [15:0] r_sd_cnr[NCOR+4];
    logic [15:0] r_sd_cnb[NCOR+4];
    logic [15:0] r_sd_cnp[NCOR+4];
    logic        r_sd_err[NCOR+4];
    logic [CW-1:0] n_rn, n_pn;
    assign n_rn = (CW'(r_ri) + 1'b1 == r_n) ? '0 : CW'(r_ri) + 1'b1;
    assign n_pn = (CW'(r_pi) + 1'b1 == r_m) ? '0 : CW'(r_pi) + 1'b1;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sd_ch[0]  <= 16'(r_ri) * 16'(r_m) + 16'(r_pi);
            r_sd_cnr[0] <= 16'(n_rn) * 16'(r_m) + 16'(r_pi);
            r_sd_cnb[0] <= 16'(n_rn) * 16'(r_m) + 16'(n_pn);
            r_sd_cnp[0] <= 16'(r_ri) * 16'(r_m) + 16'(n_pn);
            r_sd_err[0] <= r_err;
            for (int k = 1; k < NCOR + 4; k++) begin
                r_sd_ch[k]  <= r_sd_ch[k-1];
                r_sd_cnr[k] <= r_sd_cnr[k-1];
                r_sd_cnb[k] <= r_sd_cnb[k-1];
                r_sd_cnp[k] <= r_sd_cnp[k-1];
                r_sd_err[k] <= r_sd_err[k-1];
            end
        end
    end

    // Stage B: quadrant fixup, rounding to Q.16, clamp.
    function automatic logic signed [17:0] to_unit(input tvqg_pkg::t_cval v);
        logic signed [33:0] t;
        t = (v + 34'sd8192) >>> 14;
        if (t > 34'sd65536) return 18'sd65536;
        if (t < -34'sd65536) return -18'sd65536;
        return 18'(t);
    endfunction

    tvqg_pkg::t_cval n_co, n_so, n_cg, n_sg;
    always_comb begin
        unique case (c_q.quad_o)
            2'd0: begin n_co = c_xo;  n_so = c_yo;  end
            2'd1: begin n_co = -c_yo; n_so = c_xo;  end
            2'd2: begin n_co = -c_xo; n_so = -c_yo; end
            default: begin n_co = c_yo; n_so = -c_xo; end
        endcase
        unique case (c_q.quad_g)
            2'd0: begin n_cg = c_xg;  n_sg = c_yg;  end
            2'd1: begin n_cg = -c_yg; n_sg = c_xg;  end
            2'd2: begin n_cg = -c_xg; n_sg = -c_yg; end
            default: begin n_cg = c_yg; n_sg = -c_xg; end
        endcase
    end

    logic signed [17:0] r_co, r_so, r_cg, r_sg;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_co <= to_unit(n_co);
            r_so <= to_unit(n_so);
            r_cg <= to_unit(n_cg);
            r_sg <= to_unit(n_sg);
        end
    end

    // Stage C: r*cos g and r*sin g.
    logic signed [34:0] r_rcg, r_rsg;
    logic signed [17:0] r_co2, r_so2;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rcg <= 35'($signed({1'b0, r_minor}) * r_cg);
            r_rsg <= 35'($signed({1'b0, r_minor}) * r_sg);
            r_co2 <= r_co;
            r_so2 <= r_so;
        end
    end

    // Stage D: rho and z.
    logic signed [35:0] r_rho;
    logic signed [17:0] r_z, r_co3, r_so3;
    logic signed [34:0] n_zt;
    assign n_zt = (r_rsg + 35'sd32768) >>> 16;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rho <= $signed({4'd0, r_major, 16'd0}) + 36'(r_rcg);
            r_z   <= (n_zt > 35'sd131071) ? 18'sd131071 :
                     (n_zt < -35'sd131072) ? -18'sd131072 : 18'(n_zt);
            r_co3 <= r_co2;
            r_so3 <= r_so2;
        end
    end

    // Stage E: rho products.
    logic signed [53:0] r_px, r_py;
    logic signed [17:0] r_z2;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_px <= 54'(r_rho * r_co3);
            r_py <= 54'(r_rho * r_so3);
            r_z2 <= r_z;
        end
    end

    // Stage F: rounding, saturation, output register.
    function automatic logic signed [17:0] sat_q(input logic signed [53:0] p);
        logic signed [53:0] t;
        t = (p + 54'sd2147483648) >>> 32;
        if (t > 54'sd131071) return 18'sd131071;
        if (t < -54'sd131072) return -18'sd131072;
        return 18'(t);
    endfunction

    localparam int L = NCOR + 3;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_index_error       <= r_sd_err[L];
            o_x_coord           <= r_sd_err[L] ? '0 : sat_q(r_px);
            o_y_coord           <= r_sd_err[L] ? '0 : sat_q(r_py);
            o_z_coord           <= r_sd_err[L] ? '0 : r_z2;
            o_corner_here       <= r_sd_err[L] ? '0 : r_sd_ch[L];
            o_corner_next_ring  <= r_sd_err[L] ? '0 : r_sd_cnr[L];
            o_corner_next_both  <= r_sd_err[L] ? '0 : r_sd_cnb[L];
            o_corner_next_point <= r_sd_err[L] ? '0 : r_sd_cnp[L];
        end
    end

    assign o_valid = r_vld[LAT-1];

endmodule

### sv/tvqg_cordic.sv
// ============================================================================
// Torus CORDIC pipeline
// Sixteen registered rotation stages for two angles at once, with quadrant
// reduction on entry. Advances when i_en is high.
// ============================================================================
module tvqg_cordic (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [31:0]                  i_phase_o,
    input  logic [31:0]                  i_phase_g,
    output tvqg_pkg::t_cval              o_xo,
    output tvqg_pkg::t_cval              o_yo,
    output tvqg_pkg::t_cval              o_xg,
    output tvqg_pkg::t_cval              o_yg,
    output tvqg_pkg::t_quads             o_quads
);

    localparam int N = tvqg_pkg::CordicSteps;

    tvqg_pkg::t_cval  r_xo [N+1];
    tvqg_pkg::t_cval  r_yo [N+1];
    tvqg_pkg::t_cval  r_zo [N+1];
    tvqg_pkg::t_cval  r_xg [N+1];
    tvqg_pkg::t_cval  r_yg [N+1];
    tvqg_pkg::t_cval  r_zg [N+1];
    tvqg_pkg::t_quads r_q  [N+1];

    logic [1:0]  n_qo, n_qg;
    logic [31:0] n_reso, n_resg;

    always_comb begin
        n_qo   = 2'((i_phase_o + 32'h2000_0000) >> 30);
        n_qg   = 2'((i_phase_g + 32'h2000_0000) >> 30);
        n_reso = i_phase_o - {n_qo, 30'd0};
        n_resg = i_phase_g - {n_qg, 30'd0};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xo[0] <= tvqg_pkg::CordicStart;
            r_yo[0] <= '0;
            r_zo[0] <= 34'(signed'(n_reso));
            r_xg[0] <= tvqg_pkg::CordicStart;
            r_yg[0] <= '0;
            r_zg[0] <= 34'(signed'(n_resg));
            r_q[0]  <= '{quad_o: n_qo, quad_g: n_qg};
        end
    end

    for (genvar s = 0; s < N; s++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_zo[s][33]) begin
                    r_xo[s+1] <= r_xo[s] - (r_yo[s] >>> s);
                    r_yo[s+1] <= r_yo[s] + (r_xo[s] >>> s);
                    r_zo[s+1] <= r_zo[s] - tvqg_pkg::atan_turn(s);
                end else begin
                    r_xo[s+1] <= r_xo[s] + (r_yo[s] >>> s);
                    r_yo[s+1] <= r_yo[s] - (r_xo[s] >>> s);
                    r_zo[s+1] <= r_zo[s] + tvqg_pkg::atan_turn(s);
                end
                if (!r_zg[s][33]) begin
                    r_xg[s+1] <= r_xg[s] - (r_yg[s] >>> s);
                    r_yg[s+1] <= r_yg[s] + (r_xg[s] >>> s);
                    r_zg[s+1] <= r_zg[s] - tvqg_pkg::atan_turn(s);
                end else begin
                    r_xg[s+1] <= r_xg[s] + (r_yg[s] >>> s);
                    r_yg[s+1] <= r_yg[s] - (r_xg[s] >>> s);
                    r_zg[s+1] <= r_zg[s] + tvqg_pkg::atan_turn(s);
                end
                r_q[s+1] <= r_q[s];
            end
        end
    end

    assign o_xo    = r_xo[N];
    assign o_yo    = r_yo[N];
    assign o_xg    = r_xg[N];
    assign o_yg    = r_yg[N];
    assign o_quads = r_q[N];

endmodule

### bench/tb.sv
// ============================================================================
// Torus vertex and quad generator testbench
// Streams grid positions through the generator under several register
// settings, predicts every vertex and quad word with a CORDIC model written
// here, and compares each result word field by field in arrival order.
// ============================================================================
module tb;

    localparam logic [2:0] RegSpareLo = 3'd6;
    localparam logic [2:0] RegSpareHi = 3'd7;
    localparam int PipeDrain = 40;
    localparam int CycleLimit = 300000;

    localparam longint AtanTurn[16] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
        64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D
    };

    typedef struct {
        logic signed [17:0] x;
        logic signed [17:0] y;
        logic signed [17:0] z;
        logic [15:0]        here;
        logic [15:0]        next_ring;
        logic [15:0]        next_both;
        logic [15:0]        next_point;
        logic               err;
    } t_vertex;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [7:0]         i_ring_index = '0;
    logic [7:0]         i_point_index = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [17:0] o_x_coord;
    logic signed [17:0] o_y_coord;
    logic signed [17:0] o_z_coord;
    logic [15:0]        o_corner_here;
    logic [15:0]        o_corner_next_ring;
    logic [15:0]        o_corner_next_both;
    logic [15:0]        o_corner_next_point;
    logic               o_index_error;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_index = '0;
    logic [15:0]        i_cfg_data = '0;

    longint major_r, minor_r, rings, points, ring_step, point_step;
    t_vertex pending_vertices[$];
    int  errors = 0;
    int  cycles = 0;
    bit  no_idle = 1'b0;

    torus_vertex_and_quad_generator uut (.*);

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_stall <= !no_idle && ($urandom_range(99) < 9);
    end

    function automatic void turn_sin_cos(input logic [15:0] ph, output longint c,
                                         output longint s);
        bit [31:0] a, res;
        bit [1:0] q;
        longint x, y, z, dx, dy, cx, cy, t;
        a = {ph, 16'h0};
        q = 2'((a + 32'h20000000) >> 30);
        res = a - {q, 30'b0};
        z = longint'(signed'(res));
        x = 652032874;
        y = 0;
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= AtanTurn[i];
            end else begin
                x += dx; y -= dy; z += AtanTurn[i];
            end
        end
        case (q)
            2'd0: begin cx = x;  cy = y;  end
            2'd1: begin cx = -y; cy = x;  end
            2'd2: begin cx = -x; cy = -y; end
            default: begin cx = y; cy = -x; end
        endcase
        t = (cx + 8192) >>> 14;
        c = t > 65536 ? 65536 : (t < -65536 ? -65536 : t);
        t = (cy + 8192) >>> 14;
        s = t > 65536 ? 65536 : (t < -65536 ? -65536 : t);
    endfunction

    function automatic longint sat18(input longint v);
        return v > 131071 ? 131071 : (v < -131072 ? -131072 : v);
    endfunction

    function automatic t_vertex torus_vertex(input int ri, input int pi);
        t_vertex r;
        longint n, m, co, so, cg, sg, rho, rn, pn;
        n = rings > tvqg_pkg::MaxRingSize ? tvqg_pkg::MaxRingSize : rings;
        m = points > tvqg_pkg::MaxRingSize ? tvqg_pkg::MaxRingSize : points;
        r = '{default: '0};
        if (ri >= n || pi >= m) begin
            r.err = 1'b1;
            return r;
        end
        turn_sin_cos(16'(ri * ring_step), co, so);
        turn_sin_cos(16'(pi * point_step), cg, sg);
        rho = (major_r <<< 16) + minor_r * cg;
        r.x = 18'(sat18((rho * co + 64'sd2147483648) >>> 32));
        r.y = 18'(sat18((rho * so + 64'sd2147483648) >>> 32));
        r.z = 18'(sat18((minor_r * sg + 32768) >>> 16));
        rn = (ri + 1 == n) ? 0 : ri + 1;
        pn = (pi + 1 == m) ? 0 : pi + 1;
        r.here       = 16'(ri * m + pi);
        r.next_ring  = 16'(rn * m + pi);
        r.next_both  = 16'(rn * m + pn);
        r.next_point = 16'(ri * m + pn);
        return r;
    endfunction

    task automatic send_position(input int ri, input int pi);
        @(negedge i_clk);
        while (!no_idle && $urandom_range(99) < 9) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_ring_index <= 8'(ri);
        i_point_index <= 8'(pi);
        do @(posedge i_clk); while (o_stall);
        pending_vertices = {pending_vertices, torus_vertex(ri, pi)};
    endtask

    // Registers change only once the pipeline has drained.
    task automatic quiesce();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_vertices.size() != 0) @(posedge i_clk);
        repeat (PipeDrain) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            tvqg_pkg::REG_MAJOR:  major_r = val;
            tvqg_pkg::REG_MINOR:  minor_r = val;
            tvqg_pkg::REG_RINGS:  rings = val & 16'h1FF;
            tvqg_pkg::REG_POINTS: points = val & 16'h1FF;
            tvqg_pkg::REG_RSTEP:  ring_step = val;
            tvqg_pkg::REG_PSTEP:  point_step = val;
            default: ;
        endcase
    endtask

    task automatic set_all(input logic [15:0] maj, input logic [15:0] mnr,
                           input logic [15:0] nr, input logic [15:0] np,
                           input logic [15:0] rs, input logic [15:0] ps);
        quiesce();
        write_reg(tvqg_pkg::REG_MAJOR, maj);
        write_reg(tvqg_pkg::REG_MINOR, mnr);
        write_reg(tvqg_pkg::REG_RINGS, nr);
        write_reg(tvqg_pkg::REG_POINTS, np);
        write_reg(tvqg_pkg::REG_RSTEP, rs);
        write_reg(tvqg_pkg::REG_PSTEP, ps);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_reset_corners();
        send_position(0, 0);
        send_position(99, 99);
        send_position(0, 99);
        send_position(99, 0);
        send_position(100, 0);
        send_position(0, 100);
        send_position(255, 255);
    endtask

    task automatic test_count_extremes();
        set_all(16'hFFFF, 16'hFFFF, 16'd256, 16'd1, 16'hFFFF, 16'hFFFF);
        send_position(255, 0);
        send_position(128, 0);
        send_position(0, 1);
        set_all(16'd0, 16'd0, 16'h1FF, 16'd0, 16'd0, 16'd0);
        send_position(255, 0);
        send_position(3, 0);
        set_all(16'h8000, 16'h4000, 16'd1, 16'd256, 16'd16384, 16'd32768);
        send_position(0, 255);
        send_position(0, 128);
        send_position(1, 7);
    endtask

    task automatic test_spare_registers();
        quiesce();
        write_reg(RegSpareLo, 16'hFFFF);
        write_reg(RegSpareHi, 16'h0000);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        send_position(0, 17);
        send_position(0, 255);
    endtask

    task automatic test_random_mesh(input int phases, input int per_phase);
        int n, m;
        for (int ph = 0; ph < phases; ph++) begin
            if (ph == 0)
                set_all(16'($urandom), 16'($urandom), 16'd256, 16'd256,
                        16'($urandom), 16'($urandom));
            else
                set_all(($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom),
                        ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom),
                        16'($urandom_range(7) == 0 ? $urandom_range(511)
                                                     : $urandom_range(256, 1)),
                        16'($urandom_range(7) == 0 ? $urandom_range(511)
                                                     : $urandom_range(256, 1)),
                        16'($urandom), 16'($urandom));
            no_idle = (ph == 2);
            n = rings > tvqg_pkg::MaxRingSize ? tvqg_pkg::MaxRingSize : int'(rings);
            m = points > tvqg_pkg::MaxRingSize ? tvqg_pkg::MaxRingSize : int'(points);
            for (int k = 0; k < per_phase; k++) begin
                if (n > 0 && m > 0 && $urandom_range(99) < 88)
                    send_position($urandom_range(n - 1), $urandom_range(m - 1));
                else
                    send_position($urandom_range(255), $urandom_range(255));
            end
            no_idle = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        t_vertex e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_vertices.size() == 0) begin
                $display("%0t: result word with nothing expected", $time);
                errors++;
            end else begin
                e = pending_vertices.pop_front();
                if (o_x_coord !== e.x || o_y_coord !== e.y || o_z_coord !== e.z ||
                    o_corner_here !== e.here || o_corner_next_ring !== e.next_ring ||
                    o_corner_next_both !== e.next_both ||
                    o_corner_next_point !== e.next_point || o_index_error !== e.err) begin
                    $display("%0t: expected xyz %0d %0d %0d quad %0d %0d %0d %0d err %0b",
                             $time, e.x, e.y, e.z, e.here, e.next_ring, e.next_both,
                             e.next_point, e.err);
                    $display("%0t: actual   xyz %0d %0d %0d quad %0d %0d %0d %0d err %0b",
                             $time, o_x_coord, o_y_coord, o_z_coord, o_corner_here,
                             o_corner_next_ring, o_corner_next_both,
                             o_corner_next_point, o_index_error);
                    errors++;
                end
            end
        end
    end

    initial begin
        major_r = 512; minor_r = 256; rings = 100; points = 100;
        ring_step = 655; point_step = 655;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_corners();
        test_count_extremes();
        test_spare_registers();
        test_random_mesh(10, 188);
        quiesce();
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
